>>> sv/cpu6502_pkg.sv
// Package with the types and constants of the 6502 execute unit.
package cpu6502_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0, OP_AND = 6'd1, OP_ASL = 6'd2, OP_BCC = 6'd3, OP_BCS = 6'd4,
		OP_BEQ = 6'd5, OP_BIT = 6'd6, OP_BMI = 6'd7, OP_BNE = 6'd8, OP_BPL = 6'd9,
		OP_BVC = 6'd10, OP_BVS = 6'd11, OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14,
		OP_CLV = 6'd15, OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
		OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23, OP_INX = 6'd24,
		OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27, OP_LDY = 6'd28, OP_LSR = 6'd29,
		OP_NOP = 6'd30, OP_ORA = 6'd31, OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34,
		OP_PLP = 6'd35, OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
		OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43, OP_STY = 6'd44,
		OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47, OP_TXA = 6'd48, OP_TXS = 6'd49,
		OP_TYA = 6'd50, OP_JMP = 6'd51, OP_JSR = 6'd52, OP_RTI = 6'd53, OP_RTS = 6'd54,
		OP_BRK = 6'd55
	} op_t;

	localparam int unsigned ADDR_WIDTH = 16;

	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_I = 2;
	localparam int unsigned FL_D = 3;
	localparam int unsigned FL_B = 4;
	localparam int unsigned FL_U = 5;
	localparam int unsigned FL_V = 6;
	localparam int unsigned FL_N = 7;

	localparam logic [7:0] STACK_PAGE = 8'h01;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET = 8'h24;

	typedef struct packed {
		logic [5:0] func;
		logic [ADDR_WIDTH-1:0] operand_addr;
		logic [7:0] operand_value;
		logic use_accumulator;
		logic signed [7:0] branch_offset;
		logic [ADDR_WIDTH-1:0] jump_target;
		logic [ADDR_WIDTH-1:0] pc_now;
		logic [7:0] pop_first;
		logic [7:0] pop_second;
		logic [7:0] pop_third;
	} in_word_t;

	typedef struct packed {
		logic write_valid;
		logic [ADDR_WIDTH-1:0] write_addr;
		logic [7:0] write_data;
		logic last;
		logic [ADDR_WIDTH-1:0] next_pc;
		logic [7:0] accumulator_view;
		logic [7:0] x_view;
		logic [7:0] y_view;
		logic [7:0] stack_view;
		logic [7:0] flags_view;
	} out_word_t;

endpackage

>>> sv/cpu6502_execute_unit.sv
// Top level of the 6502 execute unit: register file, ALU and write sequencing.
//
// One instruction word is taken per cycle while the output register is free; its
// first result word appears in the next cycle. Instructions without a memory write,
// or with one, give one result word; JSR gives two and BRK three, so those hold the
// input while the further stack writes drain from a small write buffer.
module cpu6502_execute_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cpu6502_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output cpu6502_pkg::out_word_t out_word
);
	import cpu6502_pkg::*;

	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [7:0] a_d, x_d, y_d, sp_d, p_d;
	logic [ADDR_WIDTH-1:0] npc;
	logic [1:0] nw;
	logic [ADDR_WIDTH-1:0] wa [3];
	logic [7:0] wd [3];

	// Pending writes of the instruction in the output stage.
	out_word_t cur_q;
	logic [ADDR_WIDTH-1:0] pa_q [2];
	logic [7:0] pd_q [2];
	logic [1:0] pend_q;

	logic [7:0] m, src, r, sum8;
	logic [8:0] sum;
	logic [7:0] addend;
	logic [ADDR_WIDTH-1:0] ret, br;
	logic take;
	logic cin;
	op_t op;

	assign op = op_t'(in_word.func);
	assign m = in_word.operand_value;
	assign cin = p_q[FL_C];
	assign src = in_word.use_accumulator ? a_q : m;
	assign ret = in_word.pc_now + 16'd1;
	assign br = ret + {{8{in_word.branch_offset[7]}}, in_word.branch_offset};
	assign addend = (op == OP_SBC) ? ~m : m;
	assign sum = {1'b0, a_q} + {1'b0, addend} + {8'd0, cin};
	assign sum8 = sum[7:0];

	always_comb begin
		a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
		npc = in_word.pc_now;
		nw = 2'd0;
		take = 1'b0;
		r = 8'd0;
		for (int i = 0; i < 3; i++) begin
			wa[i] = '0; wd[i] = 8'd0;
		end
		unique case (op)
			OP_ADC, OP_SBC: begin
				a_d = sum8; p_d[FL_C] = sum[8];
				p_d[FL_V] = (a_q[7] ^ sum8[7]) & (addend[7] ^ sum8[7]);
				p_d[FL_Z] = sum8 == 8'd0; p_d[FL_N] = sum8[7];
			end
			OP_AND, OP_EOR, OP_ORA, OP_LDA: begin
				if (op == OP_AND) a_d = a_q & m;
				else if (op == OP_EOR) a_d = a_q ^ m;
				else if (op == OP_ORA) a_d = a_q | m;
				else a_d = m;
				p_d[FL_Z] = a_d == 8'd0; p_d[FL_N] = a_d[7];
			end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				if (op == OP_ASL) begin p_d[FL_C] = src[7]; r = {src[6:0], 1'b0}; end
				else if (op == OP_LSR) begin p_d[FL_C] = src[0]; r = {1'b0, src[7:1]}; end
				else if (op == OP_ROL) begin p_d[FL_C] = src[7]; r = {src[6:0], cin}; end
				else begin p_d[FL_C] = src[0]; r = {cin, src[7:1]}; end
				p_d[FL_Z] = r == 8'd0; p_d[FL_N] = r[7];
				if (in_word.use_accumulator) a_d = r;
				else begin nw = 2'd1; wa[0] = in_word.operand_addr; wd[0] = r; end
			end
			OP_BCC: take = !p_q[FL_C];
			OP_BCS: take = p_q[FL_C];
			OP_BEQ: take = p_q[FL_Z];
			OP_BNE: take = !p_q[FL_Z];
			OP_BMI: take = p_q[FL_N];
			OP_BPL: take = !p_q[FL_N];
			OP_BVC: take = !p_q[FL_V];
			OP_BVS: take = p_q[FL_V];
			OP_BIT: begin
				p_d[FL_Z] = (a_q & m) == 8'd0; p_d[FL_V] = m[6]; p_d[FL_N] = m[7];
			end
			OP_CLC: p_d[FL_C] = 1'b0;
			OP_CLD: p_d[FL_D] = 1'b0;
			OP_CLI: p_d[FL_I] = 1'b0;
			OP_CLV: p_d[FL_V] = 1'b0;
			OP_SEC: p_d[FL_C] = 1'b1;
			OP_SED: p_d[FL_D] = 1'b1;
			OP_SEI: p_d[FL_I] = 1'b1;
			OP_CMP, OP_CPX, OP_CPY: begin
				if (op == OP_CMP) r = a_q;
				else if (op == OP_CPX) r = x_q;
				else r = y_q;
				p_d[FL_C] = r >= m;
				r = r - m;
				p_d[FL_Z] = r == 8'd0; p_d[FL_N] = r[7];
			end
			OP_DEC, OP_INC: begin
				r = (op == OP_DEC) ? m - 8'd1 : m + 8'd1;
				p_d[FL_Z] = r == 8'd0; p_d[FL_N] = r[7];
				nw = 2'd1; wa[0] = in_word.operand_addr; wd[0] = r;
			end
			OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
				if (op == OP_DEX) x_d = x_q - 8'd1;
				else if (op == OP_INX) x_d = x_q + 8'd1;
				else if (op == OP_LDX) x_d = m;
				else if (op == OP_TAX) x_d = a_q;
				else x_d = sp_q;
				p_d[FL_Z] = x_d == 8'd0; p_d[FL_N] = x_d[7];
			end
			OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
				if (op == OP_DEY) y_d = y_q - 8'd1;
				else if (op == OP_INY) y_d = y_q + 8'd1;
				else if (op == OP_LDY) y_d = m;
				else y_d = a_q;
				p_d[FL_Z] = y_d == 8'd0; p_d[FL_N] = y_d[7];
			end
			OP_TXA, OP_TYA: begin
				a_d = (op == OP_TXA) ? x_q : y_q;
				p_d[FL_Z] = a_d == 8'd0; p_d[FL_N] = a_d[7];
			end
			OP_TXS: sp_d = x_q;
			OP_PHA, OP_PHP: begin
				nw = 2'd1; wa[0] = ADDR_WIDTH'({STACK_PAGE, sp_q});
				wd[0] = (op == OP_PHA) ? a_q : (p_q | 8'h30);
				sp_d = sp_q - 8'd1;
			end
			OP_PLA: begin
				sp_d = sp_q + 8'd1; a_d = in_word.pop_first;
				p_d[FL_Z] = a_d == 8'd0; p_d[FL_N] = a_d[7];
			end
			OP_PLP: begin
				sp_d = sp_q + 8'd1; p_d = (in_word.pop_first & 8'hCF) | 8'h20;
			end
			OP_STA: begin nw = 2'd1; wa[0] = in_word.operand_addr; wd[0] = a_q; end
			OP_STX: begin nw = 2'd1; wa[0] = in_word.operand_addr; wd[0] = x_q; end
			OP_STY: begin nw = 2'd1; wa[0] = in_word.operand_addr; wd[0] = y_q; end
			OP_JMP: npc = in_word.jump_target;
			OP_JSR, OP_BRK: begin
				wa[0] = ADDR_WIDTH'({STACK_PAGE, sp_q}); wd[0] = ret[15:8];
				wa[1] = ADDR_WIDTH'({STACK_PAGE, 8'(sp_q - 8'd1)}); wd[1] = ret[7:0];
				npc = in_word.jump_target;
				if (op == OP_JSR) begin
					nw = 2'd2; sp_d = sp_q - 8'd2;
				end else begin
					nw = 2'd3; sp_d = sp_q - 8'd3;
					wa[2] = ADDR_WIDTH'({STACK_PAGE, 8'(sp_q - 8'd2)});
					wd[2] = p_q | 8'h30; p_d[FL_I] = 1'b1;
				end
			end
			OP_RTI: begin
				sp_d = sp_q + 8'd3; p_d = (in_word.pop_first & 8'hCF) | 8'h20;
				npc = {in_word.pop_third, in_word.pop_second};
			end
			OP_RTS: begin
				sp_d = sp_q + 8'd2;
				npc = {in_word.pop_second, in_word.pop_first} + 16'd1;
			end
			default: ;
		endcase
		if (take) npc = br;
	end

	logic out_free;
	logic accept;
	assign out_free = !out_valid || (out_ready && pend_q == 2'd0);
	assign in_ready = out_free;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; sp_q <= SP_RESET; p_q <= P_RESET;
			out_valid <= 1'b0; pend_q <= 2'd0;
		end else if (accept) begin
			a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
			out_valid <= 1'b1;
			pend_q <= (nw > 2'd1) ? nw - 2'd1 : 2'd0;
		end else if (out_valid && out_ready) begin
			if (pend_q != 2'd0) pend_q <= pend_q - 2'd1;
			else out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.write_valid <= nw != 2'd0;
			cur_q.write_addr <= wa[0];
			cur_q.write_data <= wd[0];
			cur_q.last <= nw <= 2'd1;
			cur_q.next_pc <= npc;
			cur_q.accumulator_view <= a_d;
			cur_q.x_view <= x_d;
			cur_q.y_view <= y_d;
			cur_q.stack_view <= sp_d;
			cur_q.flags_view <= p_d;
			pa_q[0] <= wa[1]; pd_q[0] <= wd[1];
			pa_q[1] <= wa[2]; pd_q[1] <= wd[2];
		end else if (out_valid && out_ready && pend_q != 2'd0) begin
			cur_q.write_addr <= pa_q[0];
			cur_q.write_data <= pd_q[0];
			cur_q.last <= pend_q == 2'd1;
			pa_q[0] <= pa_q[1]; pd_q[0] <= pd_q[1];
		end
	end

	assign out_word = cur_q;

	a_last_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pend_q == 2'd0 |-> cur_q.last) else $error("last missing");
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd0 |-> !in_ready) else $error("accept during pushes");
	a_pend_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd0 |-> out_valid && cur_q.write_valid) else $error("pending idle");
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd0 && out_ready |=> pend_q == $past(pend_q) - 2'd1)
		else $error("pending count");

endmodule

>>> test/cpu6502_execute_unit_tb.sv
// Testbench for the 6502 execute unit: directed table and random instructions checked by a predictor.
module cpu6502_execute_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpu6502_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;

	logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
	out_word_t pending_writes[$];
	int fail_count = 0;
	int cycle_count = 0;

	typedef struct {
		in_word_t w;
		bit has_exp;
		out_word_t exp;
	} stim_row_t;
	stim_row_t stim_table[$];

	cpu6502_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_word(in_word), .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void set_flag(int unsigned bitpos, bit on);
		cpu_p[bitpos] = on;
	endfunction

	function automatic void set_nz(logic [7:0] v);
		cpu_p[FL_Z] = (v == 8'h00);
		cpu_p[FL_N] = v[7];
	endfunction

	function automatic void add_carry(logic [7:0] m);
		logic [8:0] sum;
		sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[FL_C]};
		cpu_p[FL_V] = (cpu_a[7] ^ sum[7]) & (m[7] ^ sum[7]);
		cpu_p[FL_C] = sum[8];
		cpu_a = sum[7:0];
		set_nz(cpu_a);
	endfunction

	function automatic void cmp_reg(logic [7:0] r, logic [7:0] m);
		cpu_p[FL_C] = (r >= m);
		set_nz(r - m);
	endfunction

	function automatic void execute_instruction(in_word_t w);
		logic [15:0] addrs[$];
		logic [7:0] datas[$];
		logic [15:0] next, ret;
		logic [7:0] src, r;
		logic cin;
		bit take;
		int n;
		out_word_t o;
		next = w.pc_now;
		ret = w.pc_now + 16'd1;
		take = 1'b0;
		src = w.use_accumulator ? cpu_a : w.operand_value;
		cin = cpu_p[FL_C];
		case (op_t'(w.func))
			OP_ADC: add_carry(w.operand_value);
			OP_SBC: add_carry(~w.operand_value);
			OP_AND: begin cpu_a &= w.operand_value; set_nz(cpu_a); end
			OP_EOR: begin cpu_a ^= w.operand_value; set_nz(cpu_a); end
			OP_ORA: begin cpu_a |= w.operand_value; set_nz(cpu_a); end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				case (op_t'(w.func))
					OP_ASL: begin cpu_p[FL_C] = src[7]; r = {src[6:0], 1'b0}; end
					OP_LSR: begin cpu_p[FL_C] = src[0]; r = {1'b0, src[7:1]}; end
					OP_ROL: begin cpu_p[FL_C] = src[7]; r = {src[6:0], cin}; end
					default: begin cpu_p[FL_C] = src[0]; r = {cin, src[7:1]}; end
				endcase
				set_nz(r);
				if (w.use_accumulator) cpu_a = r;
				else begin addrs.push_back(w.operand_addr); datas.push_back(r); end
			end
			OP_BCC: take = !cpu_p[FL_C];
			OP_BCS: take = cpu_p[FL_C];
			OP_BEQ: take = cpu_p[FL_Z];
			OP_BNE: take = !cpu_p[FL_Z];
			OP_BMI: take = cpu_p[FL_N];
			OP_BPL: take = !cpu_p[FL_N];
			OP_BVC: take = !cpu_p[FL_V];
			OP_BVS: take = cpu_p[FL_V];
			OP_BIT: begin
				cpu_p[FL_Z] = ((cpu_a & w.operand_value) == 8'h00);
				cpu_p[FL_V] = w.operand_value[6];
				cpu_p[FL_N] = w.operand_value[7];
			end
			OP_CLC: set_flag(FL_C, 0);
			OP_CLD: set_flag(FL_D, 0);
			OP_CLI: set_flag(FL_I, 0);
			OP_CLV: set_flag(FL_V, 0);
			OP_SEC: set_flag(FL_C, 1);
			OP_SED: set_flag(FL_D, 1);
			OP_SEI: set_flag(FL_I, 1);
			OP_CMP: cmp_reg(cpu_a, w.operand_value);
			OP_CPX: cmp_reg(cpu_x, w.operand_value);
			OP_CPY: cmp_reg(cpu_y, w.operand_value);
			OP_DEC, OP_INC: begin
				r = (op_t'(w.func) == OP_DEC) ? w.operand_value - 8'd1 : w.operand_value + 8'd1;
				set_nz(r);
				addrs.push_back(w.operand_addr); datas.push_back(r);
			end
			OP_DEX: begin cpu_x--; set_nz(cpu_x); end
			OP_DEY: begin cpu_y--; set_nz(cpu_y); end
			OP_INX: begin cpu_x++; set_nz(cpu_x); end
			OP_INY: begin cpu_y++; set_nz(cpu_y); end
			OP_LDA: begin cpu_a = w.operand_value; set_nz(cpu_a); end
			OP_LDX: begin cpu_x = w.operand_value; set_nz(cpu_x); end
			OP_LDY: begin cpu_y = w.operand_value; set_nz(cpu_y); end
			OP_PHA, OP_PHP: begin
				addrs.push_back({STACK_PAGE, cpu_sp});
				datas.push_back(op_t'(w.func) == OP_PHA ? cpu_a : (cpu_p | 8'h30));
				cpu_sp--;
			end
			OP_PLA: begin cpu_sp++; cpu_a = w.pop_first; set_nz(cpu_a); end
			OP_PLP: begin cpu_sp++; cpu_p = (w.pop_first & 8'hCF) | 8'h20; end
			OP_STA: begin addrs.push_back(w.operand_addr); datas.push_back(cpu_a); end
			OP_STX: begin addrs.push_back(w.operand_addr); datas.push_back(cpu_x); end
			OP_STY: begin addrs.push_back(w.operand_addr); datas.push_back(cpu_y); end
			OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
			OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
			OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
			OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
			OP_TXS: cpu_sp = cpu_x;
			OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
			OP_JMP: next = w.jump_target;
			OP_JSR, OP_BRK: begin
				addrs.push_back({STACK_PAGE, cpu_sp}); datas.push_back(ret[15:8]); cpu_sp--;
				addrs.push_back({STACK_PAGE, cpu_sp}); datas.push_back(ret[7:0]); cpu_sp--;
				if (op_t'(w.func) == OP_BRK) begin
					addrs.push_back({STACK_PAGE, cpu_sp}); datas.push_back(cpu_p | 8'h30);
					cpu_sp--;
					cpu_p[FL_I] = 1'b1;
				end
				next = w.jump_target;
			end
			OP_RTI: begin
				cpu_sp += 8'd3;
				cpu_p = (w.pop_first & 8'hCF) | 8'h20;
				next = {w.pop_third, w.pop_second};
			end
			OP_RTS: begin
				cpu_sp += 8'd2;
				next = {w.pop_second, w.pop_first} + 16'd1;
			end
			default: ;
		endcase
		if (take) next = w.pc_now + 16'd1 + {{8{w.branch_offset[7]}}, w.branch_offset};
		n = (addrs.size() > 0) ? addrs.size() : 1;
		for (int k = 0; k < n; k++) begin
			o = '0;
			if (k < addrs.size()) begin
				o.write_valid = 1'b1;
				o.write_addr = addrs[k];
				o.write_data = datas[k];
			end
			o.last = (k == n - 1);
			o.next_pc = next;
			o.accumulator_view = cpu_a;
			o.x_view = cpu_x;
			o.y_view = cpu_y;
			o.stack_view = cpu_sp;
			o.flags_view = cpu_p;
			pending_writes.push_back(o);
		end
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.func = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(56, 63))
			: 6'($urandom_range(0, 55));
		w.operand_addr = 16'($urandom);
		w.operand_value = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
		w.use_accumulator = 1'($urandom);
		w.branch_offset = 8'($urandom);
		w.jump_target = 16'($urandom);
		w.pc_now = 16'($urandom);
		w.pop_first = 8'($urandom);
		w.pop_second = 8'($urandom);
		w.pop_third = 8'($urandom);
		return w;
	endfunction

	function automatic void add_row(op_t f, logic [7:0] v, bit acc, logic [15:0] pc,
			logic [7:0] off, logic [15:0] tgt, logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
		stim_row_t row;
		row.w = '0;
		row.w.func = f;
		row.w.operand_addr = 16'hFFFF;
		row.w.operand_value = v;
		row.w.use_accumulator = acc;
		row.w.pc_now = pc;
		row.w.branch_offset = off;
		row.w.jump_target = tgt;
		row.w.pop_first = p1;
		row.w.pop_second = p2;
		row.w.pop_third = p3;
		row.has_exp = 1'b0;
		stim_table.push_back(row);
	endfunction

	// Valid drops only when a gap follows, so a word sent right away keeps it high.
	task automatic drive_word(in_word_t w);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_word(in_word_t w);
		drive_word(w);
		execute_instruction(w);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		out_word_t e;
		if (out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				e = pending_writes.pop_front();
				if (out_word.write_valid !== e.write_valid) begin
					$error("write_valid exp %h got %h", e.write_valid, out_word.write_valid);
					fail_count++;
				end
				if (out_word.write_addr !== e.write_addr) begin
					$error("write_addr exp %h got %h", e.write_addr, out_word.write_addr);
					fail_count++;
				end
				if (out_word.write_data !== e.write_data) begin
					$error("write_data exp %h got %h", e.write_data, out_word.write_data);
					fail_count++;
				end
				if (out_word.last !== e.last) begin
					$error("last exp %h got %h", e.last, out_word.last);
					fail_count++;
				end
				if (out_word.next_pc !== e.next_pc) begin
					$error("next_pc exp %h got %h", e.next_pc, out_word.next_pc);
					fail_count++;
				end
				if (out_word.accumulator_view !== e.accumulator_view) begin
					$error("accumulator_view exp %h got %h", e.accumulator_view,
						out_word.accumulator_view);
					fail_count++;
				end
				if (out_word.x_view !== e.x_view) begin
					$error("x_view exp %h got %h", e.x_view, out_word.x_view);
					fail_count++;
				end
				if (out_word.y_view !== e.y_view) begin
					$error("y_view exp %h got %h", e.y_view, out_word.y_view);
					fail_count++;
				end
				if (out_word.stack_view !== e.stack_view) begin
					$error("stack_view exp %h got %h", e.stack_view, out_word.stack_view);
					fail_count++;
				end
				if (out_word.flags_view !== e.flags_view) begin
					$error("flags_view exp %h got %h", e.flags_view, out_word.flags_view);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int quiet;
		forever begin
			@(negedge clk);
			quiet = $urandom_range(0, 3);
			if (quiet == 0) out_ready <= 1'b1;
			else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		stim_row_t row;
		cpu_a = 8'h00;
		cpu_x = 8'h00;
		cpu_y = 8'h00;
		cpu_sp = SP_RESET;
		cpu_p = P_RESET;
		add_row(OP_NOP, 8'h00, 0, 16'h1234, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		stim_table[0].has_exp = 1'b1;
		stim_table[0].exp = '{write_valid: 1'b0, write_addr: 16'h0000, write_data: 8'h00,
			last: 1'b1, next_pc: 16'h1234, accumulator_view: 8'h00, x_view: 8'h00,
			y_view: 8'h00, stack_view: SP_RESET, flags_view: P_RESET};
		add_row(OP_LDA, 8'hFF, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_ADC, 8'h01, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_BCS, 8'h00, 0, 16'hFFFF, 8'h7F, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_BEQ, 8'h00, 0, 16'h0000, 8'h80, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_LDA, 8'h7F, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_ADC, 8'h01, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_SBC, 8'hFF, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_ROL, 8'h80, 1, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_ROR, 8'h01, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_PHA, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_PHP, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_PLP, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'hFF, 8'h00, 8'h00);
		add_row(OP_JSR, 8'h00, 0, 16'hFFFF, 8'h00, 16'hABCD, 8'h00, 8'h00, 8'h00);
		add_row(OP_BRK, 8'h00, 0, 16'h8000, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00);
		add_row(OP_RTI, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h10, 8'h34, 8'h12);
		add_row(OP_RTS, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'h00);
		add_row(OP_LDX, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_TXS, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_PHA, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		add_row(OP_PLA, 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h80, 8'h00, 8'h00);
		add_row(op_t'(6'd63), 8'h00, 0, 16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.has_exp) begin
				drive_word(row.w);
				pending_writes.push_back(row.exp);
				cpu_sp = row.exp.stack_view;
				cpu_p = row.exp.flags_view;
				@(negedge clk);
			end else begin
				send_word(row.w);
			end
		end
		for (int i = 0; i < 320; i++) begin
			if (i == 150) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending_writes.size() != 0) @(negedge clk);
			end
			if (i >= 200 && i < 240) begin
				in_valid <= 1'b1;
				in_word <= random_word();
				@(posedge clk);
				while (!in_ready) @(posedge clk);
				execute_instruction(in_word);
				@(negedge clk);
			end else begin
				send_word(random_word());
			end
		end
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_writes.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

>>> files.f
sv/cpu6502_pkg.sv
sv/cpu6502_execute_unit.sv
test/cpu6502_execute_unit_tb.sv
